// ----- rtl/bmu_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmu_pkg
// Shared types, constants and helpers for the bicycle motion update block.
// ----------------------------------------------------------------------------
package bmu_pkg;

	localparam int POS_W        = 32;
	localparam int CORDIC_STEPS = 16;

	localparam logic        OP_MOVE = 1'b0;
	localparam logic        OP_SET  = 1'b1;

	localparam logic [23:0] TWO_PI_U = 24'd411775;
	localparam logic signed [20:0] K_TWO_PI  = 21'sd411775;
	localparam logic signed [20:0] K_PI      = 21'sd205887;
	localparam logic signed [20:0] K_HALF_PI = 21'sd102944;
	localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;
	localparam logic [19:0] TURN_SAT = 20'd524288;
	localparam logic [45:0] RAD_LIM  = 46'd1 << 45;

	localparam int DIV_NW = 72;
	localparam int DIV_DW = 45;
	localparam int DIV_QW = 46;
	localparam int DIV_SW = 6;
	localparam logic [DIV_SW-1:0] TURN_DIV_STEPS = 6'd19;
	localparam logic [DIV_SW-1:0] RAD_DIV_STEPS  = 6'd46;

	localparam logic signed [67:0] P_MAX = (68'sd1 <<< (POS_W - 1)) - 68'sd1;
	localparam logic signed [67:0] P_MIN = -P_MAX - 68'sd1;

	typedef enum logic [2:0] {
		CFG_WHEELBASE,
		CFG_MAX_STEER,
		CFG_STRAIGHT_TOL,
		CFG_STEER_SIGMA,
		CFG_DIST_SIGMA
	} cfg_idx_t;

	typedef enum logic [4:0] {
		S_IDLE, S_SN, S_DN, S_DADD, S_MODS, S_CORS, S_TMUL, S_DMUL, S_TCHK, S_TDIV,
		S_CLH, S_CORH, S_H2, S_MODH, S_DEC, S_SX, S_SY, S_SFIN, S_RDIV, S_CL2,
		S_CORH2, S_A1, S_A2, S_A3, S_A4, S_A5, S_SETM, S_OUT
	} st_t;

	typedef struct packed {
		logic               op;
		logic signed [19:0] steer_cmd;
		logic signed [31:0] dist_cmd;
		logic signed [15:0] steer_dev;
		logic signed [15:0] dist_dev;
		logic signed [31:0] set_x;
		logic signed [31:0] set_y;
		logic signed [23:0] set_angle;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [19:0] heading;
		logic [31:0]        steps_taken;
		logic               arc_mode;
	} res_t;

	typedef struct packed {
		logic              start;
		logic [DIV_SW-1:0] steps;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              busy;
		logic [DIV_QW-1:0] quo;
	} div_rsp_t;

	typedef struct packed {
		logic signed [20:0] z;
		logic               neg;
	} fold_t;

	function automatic logic [16:0] atan_q16(input logic [4:0] i);
		logic [16:0] v;
		unique case (i)
			5'd0:    v = 17'd51472;
			5'd1:    v = 17'd30385;
			5'd2:    v = 17'd16055;
			5'd3:    v = 17'd8150;
			5'd4:    v = 17'd4091;
			5'd5:    v = 17'd2047;
			5'd6:    v = 17'd1024;
			5'd7:    v = 17'd512;
			5'd8:    v = 17'd256;
			5'd9:    v = 17'd128;
			5'd10:   v = 17'd64;
			5'd11:   v = 17'd32;
			5'd12:   v = 17'd16;
			5'd13:   v = 17'd8;
			5'd14:   v = 17'd4;
			5'd15:   v = 17'd2;
			5'd16:   v = 17'd1;
			default: v = 17'd0;
		endcase
		return v;
	endfunction

	// wrap to +-pi then fold into +-pi/2
	function automatic fold_t cordic_fold(input logic signed [19:0] a);
		fold_t f;
		logic signed [20:0] z;
		z = 21'(a);
		f.neg = 1'b0;
		if (z > K_PI) begin
			z = z - K_TWO_PI;
		end else if (z < -K_PI) begin
			z = z + K_TWO_PI;
		end
		if (z > K_HALF_PI) begin
			z = z - K_PI;
			f.neg = 1'b1;
		end else if (z < -K_HALF_PI) begin
			z = z + K_PI;
			f.neg = 1'b1;
		end
		f.z = z;
		return f;
	endfunction

	function automatic logic signed [POS_W-1:0] sat_pos(input logic signed [67:0] v);
		logic signed [67:0] r;
		if (v > P_MAX) begin
			r = P_MAX;
		end else if (v < P_MIN) begin
			r = P_MIN;
		end else begin
			r = v;
		end
		return POS_W'(r);
	endfunction

endpackage

// ----- rtl/bmu_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bmu_div
// Restoring divider, one quotient bit per cycle, remainder preloaded.
// ----------------------------------------------------------------------------
module bmu_div (
	input  logic               clk,
	input  logic               arst_n,
	input  bmu_pkg::div_req_t  req,
	output bmu_pkg::div_rsp_t  rsp
);
	import bmu_pkg::*;

	logic              busy_q;
	logic [DIV_SW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q;
	logic [DIV_DW-1:0] den_q;
	logic [DIV_NW-1:0] num_q;
	logic [DIV_QW-1:0] quo_q;
	logic [DIV_DW:0]   trial;
	logic              ge;

	assign trial = {rem_q, num_q[DIV_NW-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q  <= req.steps;
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_SW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			den_q <= req.den;
			rem_q <= DIV_DW'(req.num >> req.steps);
			num_q <= req.num << (7'(DIV_NW) - 7'(req.steps));
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIV_DW'(trial - {1'b0, den_q}) : DIV_DW'(trial);
			num_q <= num_q << 1;
			quo_q <= {quo_q[DIV_QW-2:0], ge};
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.quo  = quo_q;

endmodule

// ----- rtl/bicycle_motion_update.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bicycle_motion_update
// Fixed-point kinematic bicycle pose update with a shared CORDIC and divider.
// ----------------------------------------------------------------------------
//  channel  | signals                         | beat
//  command  | cmd_valid, cmd_ready, cmd       | one move or set item
//  result   | res_valid, res_ready, res       | one pose per item
//  config   | cfg_we, cfg_index, cfg_wdata    | one register write
//
//  a set reduces its angle in the modulo-2pi subtract loop
//  a move runs 16-step CORDIC passes on steer and heading, an arc move three,
//  and may run a 19-bit turn and, for an arc, a 46-bit radius division
//  one item at a time; cmd_ready is high only with nothing in flight
//  the result holds until taken; reset clears pose and count, sets config defaults
module bicycle_motion_update (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            cmd_valid,
	output logic            cmd_ready,
	input  bmu_pkg::cmd_t   cmd,
	output logic            res_valid,
	input  logic            res_ready,
	output bmu_pkg::res_t   res,
	input  logic            cfg_we,
	input  logic [2:0]      cfg_index,
	input  logic [23:0]     cfg_wdata
);
	import bmu_pkg::*;

	localparam logic [4:0] LAST_STEP = 5'(CORDIC_STEPS - 1);

	st_t state_q, state_d;

	logic [23:0] wb_q;
	logic [16:0] ms_q;
	logic [15:0] tol_q;
	logic [15:0] ssig_q;
	logic [19:0] dsig_q;

	cmd_t cmd_q;
	logic signed [21:0] steer_q;
	logic signed [33:0] dist_q;
	logic signed [POS_W-1:0] x_q, y_q;
	logic signed [19:0] hd_q;
	logic [31:0] cnt_q;
	logic arc_q;

	logic [23:0] mod_mag_q;
	logic mod_neg_q;
	logic signed [33:0] cx_q, cy_q;
	logic signed [20:0] cz_q;
	logic cneg_q;
	logic [4:0] ci_q;

	logic signed [54:0] prod_q, t_q;
	logic signed [67:0] acc_q;
	logic signed [20:0] turn_q;
	logic tneg_q, rneg_q;
	logic signed [19:0] hs_q, hc_q, h2_q;
	logic signed [46:0] r_q;

	logic signed [34:0] ma;
	logic signed [19:0] mb;
	logic signed [19:0] sin_o, cos_o, mod_res, cor_ang, dsx, dcy;
	logic signed [24:0] mod_in;
	logic mod_ge, mod_load, cor_load, cor_run, cor_last, accept;
	fold_t fold;
	logic signed [33:0] dx, dy;
	logic signed [20:0] at;
	logic [54:0] ut;
	logic [44:0] ud;
	logic signed [44:0] d_val;
	logic t_zero, t_sat, straight, r_sat;
	logic [19:0] tmag;
	logic [33:0] dmag;
	logic [DIV_NW-1:0] r_num;
	logic [23:0] wb_eff;
	logic signed [17:0] lim;
	logic [45:0] qclip;
	div_req_t div_req;
	div_rsp_t div_rsp;

	bmu_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign accept   = cmd_valid && cmd_ready;
	assign wb_eff   = (wb_q == 24'd0) ? 24'd1 : wb_q;
	assign lim      = $signed({1'b0, ms_q});
	assign mod_ge   = mod_mag_q >= TWO_PI_U;
	assign mod_res  = mod_neg_q ? -$signed(20'(mod_mag_q)) : $signed(20'(mod_mag_q));
	assign cos_o    = cneg_q ? -20'(cx_q >>> 14) : 20'(cx_q >>> 14);
	assign sin_o    = cneg_q ? -20'(cy_q >>> 14) : 20'(cy_q >>> 14);
	assign dsx      = sin_o - hs_q;
	assign dcy      = hc_q - cos_o;
	assign cor_last = ci_q == LAST_STEP;
	assign cor_run  = (state_q == S_CORS) || (state_q == S_CORH) || (state_q == S_CORH2);
	assign dx       = cy_q >>> ci_q;
	assign dy       = cx_q >>> ci_q;
	assign at       = $signed({4'd0, atan_q16(ci_q)});

	assign ut       = t_q[54] ? 55'(-t_q) : 55'(t_q);
	assign d_val    = prod_q[44:0];
	assign ud       = d_val[44] ? 45'(-d_val) : 45'(d_val);
	assign t_zero   = ut == 55'd0;
	assign t_sat    = (ud == 45'd0) || (ut >= 55'({ud, 3'b000}));
	assign tmag     = turn_q[20] ? 20'(-turn_q) : 20'(turn_q);
	assign straight = (turn_q == 21'sd0) || (tmag < 20'(tol_q));
	assign dmag     = dist_q[33] ? 34'(-dist_q) : 34'(dist_q);
	assign r_num    = DIV_NW'(dmag) << 16;
	assign r_sat    = (r_num >> 46) >= DIV_NW'(tmag);
	assign qclip    = (div_rsp.quo > RAD_LIM) ? RAD_LIM : div_rsp.quo;

	always_comb begin
		div_req.start = ((state_q == S_TCHK) && !t_zero && !t_sat)
			|| ((state_q == S_DEC) && !straight && !r_sat);
		if (state_q == S_DEC) begin
			div_req.steps = RAD_DIV_STEPS;
			div_req.num   = r_num;
			div_req.den   = DIV_DW'(tmag);
		end else begin
			div_req.steps = TURN_DIV_STEPS;
			div_req.num   = DIV_NW'(ut) << 16;
			div_req.den   = ud;
		end
	end

	always_comb begin
		mod_load = 1'b0;
		mod_in   = 25'(cmd.set_angle);
		unique case (state_q)
			S_IDLE: mod_load = accept && (cmd.op == OP_SET);
			S_DADD: begin
				mod_load = 1'b1;
				mod_in   = 25'(steer_q);
			end
			S_H2: begin
				mod_load = 1'b1;
				mod_in   = 25'(hd_q) + 25'(turn_q);
			end
			default: mod_load = 1'b0;
		endcase
	end

	always_comb begin
		cor_load = 1'b0;
		cor_ang  = hd_q;
		unique case (state_q)
			S_MODS: begin
				cor_load = !mod_ge;
				cor_ang  = mod_res;
			end
			S_CLH:  cor_load = 1'b1;
			S_CL2: begin
				cor_load = 1'b1;
				cor_ang  = h2_q;
			end
			default: cor_load = 1'b0;
		endcase
	end
	assign fold = cordic_fold(cor_ang);

	always_comb begin
		ma = '0;
		mb = '0;
		unique case (state_q)
			S_SN: begin
				ma = $signed({19'd0, ssig_q});
				mb = 20'(cmd_q.steer_dev);
			end
			S_DN: begin
				ma = $signed({15'd0, dsig_q});
				mb = 20'(cmd_q.dist_dev);
			end
			S_TMUL: begin
				ma = 35'(dist_q);
				mb = sin_o;
			end
			S_DMUL: begin
				ma = $signed({11'd0, wb_eff});
				mb = cos_o;
			end
			S_SX: begin
				ma = 35'(dist_q);
				mb = hc_q;
			end
			S_SY: begin
				ma = 35'(dist_q);
				mb = hs_q;
			end
			S_A1: begin
				ma = 35'($signed(r_q[46:23]));
				mb = dsx;
			end
			S_A2: begin
				ma = $signed({12'd0, r_q[22:0]});
				mb = dsx;
			end
			S_A3: begin
				ma = 35'($signed(r_q[46:23]));
				mb = dcy;
			end
			S_A4: begin
				ma = $signed({12'd0, r_q[22:0]});
				mb = dcy;
			end
			default: ma = '0;
		endcase
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:  if (cmd_valid) begin
				state_d = (cmd.op == OP_SET) ? S_SETM : S_SN;
			end
			S_SN:    state_d = S_DN;
			S_DN:    state_d = S_DADD;
			S_DADD:  state_d = S_MODS;
			S_MODS:  if (!mod_ge) begin
				state_d = S_CORS;
			end
			S_CORS:  if (cor_last) begin
				state_d = S_TMUL;
			end
			S_TMUL:  state_d = S_DMUL;
			S_DMUL:  state_d = S_TCHK;
			S_TCHK:  state_d = (t_zero || t_sat) ? S_CLH : S_TDIV;
			S_TDIV:  if (!div_rsp.busy) begin
				state_d = S_CLH;
			end
			S_CLH:   state_d = S_CORH;
			S_CORH:  if (cor_last) begin
				state_d = S_H2;
			end
			S_H2:    state_d = S_MODH;
			S_MODH:  if (!mod_ge) begin
				state_d = S_DEC;
			end
			S_DEC:   state_d = straight ? S_SX : (r_sat ? S_CL2 : S_RDIV);
			S_SX:    state_d = S_SY;
			S_SY:    state_d = S_SFIN;
			S_SFIN:  state_d = S_OUT;
			S_RDIV:  if (!div_rsp.busy) begin
				state_d = S_CL2;
			end
			S_CL2:   state_d = S_CORH2;
			S_CORH2: if (cor_last) begin
				state_d = S_A1;
			end
			S_A1:    state_d = S_A2;
			S_A2:    state_d = S_A3;
			S_A3:    state_d = S_A4;
			S_A4:    state_d = S_A5;
			S_A5:    state_d = S_OUT;
			S_SETM:  if (!mod_ge) begin
				state_d = S_OUT;
			end
			S_OUT:   if (res_ready) begin
				state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd_ready = state_q == S_IDLE;
		res_valid = state_q == S_OUT;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q   <= 24'd65536;
			ms_q   <= 17'd51472;
			tol_q  <= 16'd66;
			ssig_q <= 16'd0;
			dsig_q <= 20'd0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_WHEELBASE:    wb_q   <= cfg_wdata;
				CFG_MAX_STEER:    ms_q   <= cfg_wdata[16:0];
				CFG_STRAIGHT_TOL: tol_q  <= cfg_wdata[15:0];
				CFG_STEER_SIGMA:  ssig_q <= cfg_wdata[15:0];
				CFG_DIST_SIGMA:   dsig_q <= cfg_wdata[19:0];
				default:          wb_q   <= wb_q;
			endcase
		end
	end

	// pose and step count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q   <= '0;
			y_q   <= '0;
			hd_q  <= '0;
			cnt_q <= '0;
			arc_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: if (accept && (cmd.op == OP_SET)) begin
					x_q   <= sat_pos(68'(cmd.set_x));
					y_q   <= sat_pos(68'(cmd.set_y));
					arc_q <= 1'b0;
				end
				S_SETM: if (!mod_ge) begin
					hd_q <= mod_res;
				end
				S_SY:   x_q <= sat_pos(68'(x_q) + 68'(prod_q >>> 16));
				S_SFIN: begin
					y_q   <= sat_pos(68'(y_q) + 68'(prod_q >>> 16));
					hd_q  <= h2_q;
					cnt_q <= cnt_q + 32'd1;
					arc_q <= 1'b0;
				end
				S_A3:   x_q <= sat_pos(68'(x_q) + ((acc_q + 68'(prod_q)) >>> 16));
				S_A5: begin
					y_q   <= sat_pos(68'(y_q) + ((acc_q + 68'(prod_q)) >>> 16));
					hd_q  <= h2_q;
					cnt_q <= cnt_q + 32'd1;
					arc_q <= 1'b1;
				end
				default: arc_q <= arc_q;
			endcase
		end
	end

	// shared multiplier, modulo loop and cordic
	always_ff @(posedge clk) begin
		prod_q <= ma * mb;
		if (mod_load) begin
			mod_neg_q <= mod_in < 0;
			mod_mag_q <= (mod_in < 0) ? 24'(-mod_in) : 24'(mod_in);
		end else if (mod_ge) begin
			mod_mag_q <= mod_mag_q - TWO_PI_U;
		end
		if (cor_load) begin
			cx_q   <= CORDIC_GAIN;
			cy_q   <= '0;
			cz_q   <= fold.z;
			cneg_q <= fold.neg;
			ci_q   <= '0;
		end else if (cor_run) begin
			if (cz_q >= 0) begin
				cx_q <= cx_q - dx;
				cy_q <= cy_q + dy;
				cz_q <= cz_q - at;
			end else begin
				cx_q <= cx_q + dx;
				cy_q <= cy_q - dy;
				cz_q <= cz_q + at;
			end
			ci_q <= ci_q + 5'd1;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: if (accept) begin
				cmd_q <= cmd;
				if (cmd.steer_cmd > lim) begin
					steer_q <= 22'(lim);
				end else if (cmd.steer_cmd < -lim) begin
					steer_q <= 22'(-lim);
				end else begin
					steer_q <= 22'(cmd.steer_cmd);
				end
				dist_q <= (cmd.dist_cmd < 0) ? 34'sd0 : 34'(cmd.dist_cmd);
			end
			S_DN:   steer_q <= steer_q + 22'(prod_q >>> 12);
			S_DADD: dist_q <= dist_q + 34'(prod_q >>> 12);
			S_DMUL: t_q <= prod_q;
			S_TCHK: begin
				tneg_q <= t_q[54] != d_val[44];
				if (t_zero) begin
					turn_q <= '0;
				end else if (t_sat) begin
					turn_q <= (t_q[54] != d_val[44]) ? -21'(TURN_SAT) : 21'(TURN_SAT);
				end
			end
			S_TDIV: if (!div_rsp.busy) begin
				turn_q <= tneg_q ? -21'(div_rsp.quo) : 21'(div_rsp.quo);
			end
			S_H2: begin
				hs_q <= sin_o;
				hc_q <= cos_o;
			end
			S_MODH: if (!mod_ge) begin
				h2_q <= mod_res;
			end
			S_DEC: begin
				rneg_q <= dist_q[33] != turn_q[20];
				if (r_sat) begin
					r_q <= (dist_q[33] != turn_q[20]) ? -47'(RAD_LIM) : 47'(RAD_LIM);
				end
			end
			S_RDIV: if (!div_rsp.busy) begin
				r_q <= rneg_q ? -47'(qclip) : 47'(qclip);
			end
			S_A2:   acc_q <= 68'(prod_q) <<< 23;
			S_A4:   acc_q <= 68'(prod_q) <<< 23;
			default: acc_q <= acc_q;
		endcase
	end

	assign res.pos_x       = 32'(x_q);
	assign res.pos_y       = 32'(y_q);
	assign res.heading     = hd_q;
	assign res.steps_taken = cnt_q;
	assign res.arc_mode    = arc_q;

`ifndef SYNTH
	a_ready_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !cmd_ready)
		else $error("command ready while a result beat waits");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd_valid && cmd_ready) |=> !cmd_ready)
		else $error("ready straight after an accepted command beat");

	a_heading_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (hd_q <= 20'sd411775 && hd_q >= -20'sd411775))
		else $error("heading outside two pi");

	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE || state_q == S_OUT) |-> !div_rsp.busy)
		else $error("divider running with no move in progress");
`endif

endmodule
